@@ src/alt_pkg.sv @@
// ----------------------------------------------------------------------------
// alt_pkg
// Shared sizes and types for the address lease table.
// ----------------------------------------------------------------------------
package alt_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  // Field widths
  localparam int ID_W    = 64;
  localparam int TIME_W  = 32;
  localparam int NODE_W  = 8;
  localparam int LADDR_W = 5;
  localparam int ENTRY_W = ID_W + TIME_W;

  // Control from the sequencer to the candidate tracker
  typedef struct packed {
    logic             init;   // new item accepted: clear candidates
    logic             step;   // slot data present this cycle
    logic [IDX_W-1:0] idx;    // slot index of that data
  } scan_ctrl_t;

  // Outcome of the scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pick;
  } scan_res_t;

endpackage

@@ src/alt_ram.sv @@
// ----------------------------------------------------------------------------
// alt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/alt_scan.sv @@
// ----------------------------------------------------------------------------
// alt_scan
// Candidate tracker: looks at one slot per cycle and keeps the match,
// the last blank slot and the oldest lease seen so far.
// ----------------------------------------------------------------------------
module alt_scan import alt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctrl_t        ctrl,
  input  logic [ID_W-1:0]   req_id,
  input  logic [TIME_W-1:0] req_time,
  input  logic [ID_W-1:0]   slot_id,
  input  logic [TIME_W-1:0] slot_time,
  output scan_res_t         res
);

  logic              found;
  logic [IDX_W-1:0]  match_idx;
  logic              have_blank;
  logic [IDX_W-1:0]  blank_idx;
  logic              have_old;
  logic [IDX_W-1:0]  old_idx;
  logic [TIME_W-1:0] old_time;
  logic [TIME_W-1:0] limit;

  // Running minimum starts at the request time
  assign limit = have_old ? old_time : req_time;

  // Candidate registers; nothing changes after a match
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      found      <= 1'b0;
      have_blank <= 1'b0;
      have_old   <= 1'b0;
    end else if (ctrl.step && !found) begin
      if (slot_id == req_id) begin
        found     <= 1'b1;
        match_idx <= ctrl.idx;
      end else if (slot_id == '0) begin
        have_blank <= 1'b1;
        blank_idx  <= ctrl.idx;
      end else if (slot_time < limit) begin
        have_old <= 1'b1;
        old_idx  <= ctrl.idx;
        old_time <= slot_time;
      end
    end
  end

  // Priority: match, then blank, then oldest, else slot zero
  always_comb begin
    res.found = found;
    if (found) begin
      res.pick = match_idx;
    end else if (have_blank) begin
      res.pick = blank_idx;
    end else if (have_old) begin
      res.pick = old_idx;
    end else begin
      res.pick = '0;
    end
  end

endmodule

@@ src/address_lease_table_lru.sv @@
// ----------------------------------------------------------------------------
// address_lease_table_lru
// Lease table: one item per request, slot chosen by match, blank or oldest.
// ----------------------------------------------------------------------------
// Each item reads every slot in turn on the single RAM read port, takes the last
// read data, writes back the chosen slot and strobes done; busy holds off a new
// item until the sequencer is back in idle, so items never overlap.
// Reset clears all slots at once through per-slot valid bits; no clearing pass.
module address_lease_table_lru import alt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [ID_W-1:0]    client_id,
  input  logic [TIME_W-1:0]  current_time,
  input  logic [NODE_W-1:0]  requester_node,
  output logic               done,
  output logic [NODE_W-1:0]  reply_node,
  output logic [ID_W-1:0]    reply_client_id,
  output logic [LADDR_W-1:0] leased_address
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_WRITE
  } state_t;

  state_t             state;
  logic               accept;
  logic [ID_W-1:0]    req_id;
  logic [TIME_W-1:0]  req_time;
  logic [NODE_W-1:0]  req_node;
  logic [IDX_W-1:0]   rd_idx;
  logic               chk_step;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_slot_valid;
  logic [TABLE_SLOTS-1:0] slot_valid;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    slot_id;
  logic [TIME_W-1:0]  slot_time;
  logic [IDX_W:0]     pick_plus;
  scan_ctrl_t         sctrl;
  scan_res_t          sres;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Slot storage: {identifier, lease time}
  assign ram_we    = (state == S_WRITE);
  assign ram_wdata = {req_id, req_time};

  alt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sres.pick),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // A slot never written since reset reads as blank
  assign slot_id   = chk_slot_valid ? ram_rdata[ENTRY_W-1:TIME_W] : '0;
  assign slot_time = ram_rdata[TIME_W-1:0];

  assign sctrl.init = accept;
  assign sctrl.step = chk_step;
  assign sctrl.idx  = chk_idx;

  alt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sctrl),
    .req_id    (req_id),
    .req_time  (req_time),
    .slot_id   (slot_id),
    .slot_time (slot_time),
    .res       (sres)
  );

  assign pick_plus = {1'b0, sres.pick} + (IDX_W+1)'(1);

  // Request latch and read-side pipeline tag
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id   <= client_id;
      req_time <= current_time;
      req_node <= requester_node;
    end
    chk_idx        <= rd_idx;
    chk_slot_valid <= slot_valid[rd_idx];
  end

  // Sequencer: read every slot, check, then write back the chosen one.
  // Busy blocks a new item until the write lands, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_idx     <= '0;
      chk_step   <= 1'b0;
      slot_valid <= '0;
      done       <= 1'b0;
    end else begin
      done     <= 1'b0;
      chk_step <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          rd_idx <= '0;
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx == IDX_W'(TABLE_SLOTS-1)) begin
            state <= S_LAST;
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        S_LAST: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          slot_valid[sres.pick] <= 1'b1;
          done            <= 1'b1;
          reply_node      <= req_node;
          reply_client_id <= req_id;
          leased_address  <= LADDR_W'(pick_plus);
          rd_idx          <= '0;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/lease_table_check_pkg.sv @@
// ----------------------------------------------------------------------------
// lease_table_check_pkg
// Tracks slot ownership and leases alongside the DUT, queues the reply each
// accepted request should produce, and checks replies in order.
// ----------------------------------------------------------------------------
package lease_table_check_pkg;
  import alt_pkg::*;

  // One expected reply
  typedef struct {
    logic [NODE_W-1:0]  node;
    logic [ID_W-1:0]    client;
    logic [LADDR_W-1:0] address;
  } lease_reply_t;

  class lease_table_scoreboard;
    bit [ID_W-1:0]   owner_id   [TABLE_SLOTS];
    bit [TIME_W-1:0] lease_tick [TABLE_SLOTS];
    lease_reply_t    expected_replies [$];
    int              errors;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        owner_id[i]   = '0;
        lease_tick[i] = '0;
      end
      errors = 0;
    endfunction

    // Choose a slot for an accepted item and update the shadow table.
    // Match wins; else the last blank seen; else the strictly oldest lease
    // (lowest index on ties); else slot 0. An id of zero matches a blank.
    function void note_request(logic [ID_W-1:0] cid, logic [TIME_W-1:0] now,
                               logic [NODE_W-1:0] node);
      lease_reply_t    reply;
      bit              found;
      bit              have_blank;
      bit              have_old;
      int              blank_idx;
      int              old_idx;
      int              pick;
      bit [TIME_W-1:0] old_tick;

      found      = 1'b0;
      have_blank = 1'b0;
      have_old   = 1'b0;
      blank_idx  = 0;
      old_idx    = 0;
      pick       = 0;
      old_tick   = now;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (owner_id[i] == cid) begin
          found = 1'b1;
          pick  = i;
          break;
        end
        if (owner_id[i] == '0) begin
          have_blank = 1'b1;
          blank_idx  = i;
        end else if (lease_tick[i] < old_tick) begin
          have_old = 1'b1;
          old_idx  = i;
          old_tick = lease_tick[i];
        end
      end

      if (!found) begin
        if (have_blank) pick = blank_idx;
        else if (have_old) pick = old_idx;
        else pick = 0;
        owner_id[pick] = cid;
      end
      lease_tick[pick] = now;

      reply.node    = node;
      reply.client  = cid;
      reply.address = LADDR_W'(pick + 1);
      expected_replies.push_back(reply);
    endfunction

    // Compare one reply against the oldest expectation
    function void check_reply(logic [NODE_W-1:0] node, logic [ID_W-1:0] cid,
                              logic [LADDR_W-1:0] address);
      lease_reply_t exp_reply;

      if (expected_replies.size() == 0) begin
        $error("unexpected reply: node %0d client_id %h address %0d", node, cid, address);
        errors++;
        return;
      end
      exp_reply = expected_replies.pop_front();
      if (node !== exp_reply.node) begin
        $error("reply_node mismatch: expected %0d, actual %0d", exp_reply.node, node);
        errors++;
      end
      if (cid !== exp_reply.client) begin
        $error("reply_client_id mismatch: expected %h, actual %h", exp_reply.client, cid);
        errors++;
      end
      if (address !== exp_reply.address) begin
        $error("leased_address mismatch: expected %0d, actual %0d",
               exp_reply.address, address);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction
  endclass

endpackage

@@ tb/address_lease_table_lru_tb.sv @@
// ----------------------------------------------------------------------------
// address_lease_table_lru_tb
// Drives lease requests into the table: a directed walk through blank fill,
// renewal, eviction and the zero-id and no-older-lease cases, then random
// traffic over a small pool of recurring ids mixed with fresh ones. Every
// done strobe is checked against a shadow table kept by the scoreboard.
// ----------------------------------------------------------------------------
module address_lease_table_lru_tb;
  import alt_pkg::*;
  import lease_table_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 1000;
  localparam int ITEMS_PHASE  = 300;
  localparam int PHASES       = 4;
  localparam int ID_POOL_SIZE = 24;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [ID_W-1:0]    client_id = '0;
  logic [TIME_W-1:0]  current_time = '0;
  logic [NODE_W-1:0]  requester_node = '0;
  logic               done;
  logic [NODE_W-1:0]  reply_node;
  logic [ID_W-1:0]    reply_client_id;
  logic [LADDR_W-1:0] leased_address;

  lease_table_scoreboard sb = new();
  int quiet_cycles = 0;

  address_lease_table_lru dut (.*);

  always #2 clk = ~clk;

  // Reply checker: the strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (!rst && done) sb.check_reply(reply_node, reply_client_id, leased_address);
  end

  // Watchdog on cycles with neither an accepted item nor a reply
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("address_lease_table_lru_tb: FAIL");
        $finish;
      end
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic [ID_W-1:0] cid, input logic [TIME_W-1:0] now,
                              input logic [NODE_W-1:0] node);
    start          <= 1'b1;
    client_id      <= cid;
    current_time   <= now;
    requester_node <= node;
    do @(posedge clk); while (busy);
    sb.note_request(cid, now, node);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every outstanding reply has been seen
  task automatic drain_replies();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];
    logic [ID_W-1:0]   cid;
    logic [TIME_W-1:0] now;
    bit [TIME_W-1:0]   tick;
    int                pick;
    bit                idling;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero id takes the first blank and leaves it blank
    send_request('0, 32'd5, 8'd0);
    // Extremes land in the highest blank slot
    send_request('1, '1, 8'hFF);
    hold_off(3);
    // Fill downward; slot 0 stays blank until last
    for (int k = 1; k <= 14; k++) send_request(ID_W'(k) + 64'h100, TIME_W'(1000 + k), 8'(k));
    send_request(64'd1, 32'd2000, 8'h55);
    // Renewal of a held id
    send_request(64'h105, 32'd3000, 8'hAA);
    hold_off(5);
    // Table full: evict the oldest lease
    send_request(64'h8000_0000_0000_0001, 32'd4000, 8'h01);
    // Renewal with an older time: that slot becomes the oldest lease and is evicted next
    send_request(64'h104, 32'd1001, 8'h02);
    send_request(64'h7777, 32'd4500, 8'h03);
    // No lease older than the request time: slot 0 is overwritten
    send_request(64'h1234_5678_9ABC_DEF0, 32'd0, 8'h80);
    // Zero id with a full table evicts and blanks a slot, then matches it
    send_request('0, 32'd6000, 8'h7F);
    send_request('0, 32'd6001, 8'hFE);
    drain_replies();

    // Recurring ids keep renewals and evictions frequent
    foreach (id_pool[k]) begin
      if (k < 6) id_pool[k] = ID_W'($urandom_range(1, 40));
      else id_pool[k] = {$urandom, $urandom};
    end
    tick = 32'd10000;

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        // Client id: mostly recurring, some fresh, some zero or small
        pick = $urandom_range(0, 99);
        if (pick < 60) cid = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        else if (pick < 88) cid = {$urandom, $urandom};
        else if (pick < 94) cid = '0;
        else cid = ID_W'($urandom_range(1, 40));

        // Request time: slowly advancing, sometimes repeated or arbitrary
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          tick += $urandom_range(1, 4);
          now = tick;
        end else if (pick < 88) begin
          now = tick;
        end else if (pick < 96) begin
          now = $urandom;
        end else begin
          tick = $urandom;
          now = tick;
        end

        send_request(cid, now, 8'($urandom_range(0, 255)));

        // Idle bursts in alternating stretches; none in the last phase
        idling = (phase < PHASES - 1) && (((n / 40) % 2) == 0);
        if (idling && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
      end
      drain_replies();
    end

    // Wait out the pipeline in case of a stray strobe
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("address_lease_table_lru_tb: PASS");
    end else begin
      $display("address_lease_table_lru_tb: FAIL");
    end
    $finish;
  end

endmodule
